// File: rtl/uaq_pkg.sv
// Shared types and codes for the unsorted array priority queue.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package uaq_pkg;

  localparam int IdW  = 16;
  localparam int PriW = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_KTH    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_RANK     = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_WRITE
  } cell_op_t;

  // Broadcast control shared by every cell of the row.
  typedef struct packed {
    cell_op_t               op;
    logic                   wr_id;
    logic [IdW-1:0]         wid;
    logic signed [PriW-1:0] wpri;
  } cell_ctl_t;

endpackage

// File: rtl/uaq_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on uaq_pkg for field widths.
interface uaq_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [uaq_pkg::IdW-1:0]         item_id;
  logic signed [uaq_pkg::PriW-1:0] item_priority;
  logic [7:0]                      rank;
  modport source (output valid, kind, item_id, item_priority, rank, input ready);
  modport sink   (input valid, kind, item_id, item_priority, rank, output ready);
endinterface

interface uaq_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic [uaq_pkg::IdW-1:0]         found_id;
  logic signed [uaq_pkg::PriW-1:0] found_priority;
  logic [7:0]                      occupancy;
  modport source (output valid, status, found_id, found_priority, occupancy, input ready);
  modport sink   (input valid, status, found_id, found_priority, occupancy, output ready);
endinterface

// File: rtl/uaq_cell.sv
// One storage cell of the queue row: holds one entry, can rotate,
// close a gap from its right neighbor, or take a broadcast write. Uses uaq_pkg.
module uaq_cell #(
  parameter int IDX = 0,
  parameter int AW  = 7,
  parameter int CW  = 8
) (
  input  logic                            clk,
  input  uaq_pkg::cell_ctl_t              ctl,
  input  logic [AW-1:0]                   pos,
  input  logic [CW-1:0]                   cnt,
  input  logic [uaq_pkg::IdW-1:0]         nbr_id,
  input  logic signed [uaq_pkg::PriW-1:0] nbr_pri,
  output logic [uaq_pkg::IdW-1:0]         id_r,
  output logic signed [uaq_pkg::PriW-1:0] pri_r
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [CW-1:0] IDX_N = CW'(IDX + 1);

  logic [CW-1:0] pos_c;
  assign pos_c = CW'(pos);

  always_ff @(posedge clk) begin
    case (ctl.op)
      uaq_pkg::CELL_ROTATE: begin
        id_r  <= nbr_id;
        pri_r <= nbr_pri;
      end
      uaq_pkg::CELL_SHIFT: begin
        if (IDX_C >= pos_c && IDX_N < cnt) begin
          id_r  <= nbr_id;
          pri_r <= nbr_pri;
        end
      end
      uaq_pkg::CELL_WRITE: begin
        if (IDX_C == pos_c) begin
          if (ctl.wr_id) id_r <= ctl.wid;
          pri_r <= ctl.wpri;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/unsorted_array_priority_queue.sv
// Unsorted array min-priority queue: top level.
// Depends on uaq_pkg, uaq_if (channels) and uaq_cell (storage row).
//
// Entries live in a row of CAPACITY cells in insertion order. Insert writes
// the cell at the fill count in the cycle it is accepted; its result then
// goes through the result state into the output register once that register
// is free. Remove-min, update and k-th search rotate the whole row past a
// comparator at cell zero, one cell a cycle, once per pass; remove-min, and
// update when the id is found, then close the gap or write the new priority
// in the apply state before the result state loads the output register.
// K-th search runs rank passes, each finding the next entry in removal order
// (priority, then position), and then goes to the result state. Empty, full
// and rank errors, and updates on an empty store, skip the scan and go
// straight to the result state. One request is worked on at a time; a new one
// is accepted while the previous result still waits in the output register.
module unsorted_array_priority_queue #(
  parameter int CAPACITY = 128
) (
  input logic     clk,
  input logic     rst_n,
  uaq_in_if.sink    in_ch,
  uaq_out_if.source out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_T = AW'(CAPACITY - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_RESULT} state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] t_r;
  logic [7:0]    pass_r;

  // request held for the duration of the work
  logic [1:0]                      kind_r;
  logic [uaq_pkg::IdW-1:0]         req_id_r;
  logic signed [uaq_pkg::PriW-1:0] req_pri_r;
  logic [7:0]                      rank_r;

  // best candidate of the current pass and the bound from the previous one
  logic                            have_best_r, have_last_r;
  logic [AW-1:0]                   best_idx_r, last_idx_r;
  logic [uaq_pkg::IdW-1:0]         best_id_r;
  logic signed [uaq_pkg::PriW-1:0] best_pri_r, last_pri_r;

  // pending result
  logic [2:0]                      res_st_r;
  logic [uaq_pkg::IdW-1:0]         res_id_r;
  logic signed [uaq_pkg::PriW-1:0] res_pri_r;

  logic                            out_valid_r;
  logic [2:0]                      out_st_r;
  logic [uaq_pkg::IdW-1:0]         out_id_r;
  logic signed [uaq_pkg::PriW-1:0] out_pri_r;
  logic [7:0]                      out_occ_r;

  uaq_pkg::cell_ctl_t              ctl;
  logic [AW-1:0]                   ctl_pos;
  logic [uaq_pkg::IdW-1:0]         c_id  [CAPACITY];
  logic signed [uaq_pkg::PriW-1:0] c_pri [CAPACITY];

  logic in_acc;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  // result register loads when it is free or being drained this cycle
  logic out_load;
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);

  // cell row control
  always_comb begin
    ctl.op    = uaq_pkg::CELL_HOLD;
    ctl.wr_id = 1'b1;
    ctl.wid   = in_ch.item_id;
    ctl.wpri  = in_ch.item_priority;
    ctl_pos   = AW'(cnt_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.kind == uaq_pkg::KIND_INSERT && cnt_r < CAP_C)
          ctl.op = uaq_pkg::CELL_WRITE;
      end
      S_SCAN: ctl.op = uaq_pkg::CELL_ROTATE;
      S_APPLY: begin
        ctl_pos = best_idx_r;
        if (kind_r == uaq_pkg::KIND_REMOVE) begin
          ctl.op = uaq_pkg::CELL_SHIFT;
        end else begin
          ctl.op    = uaq_pkg::CELL_WRITE;
          ctl.wr_id = 1'b0;
          ctl.wpri  = req_pri_r;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    uaq_cell #(.IDX(g), .AW(AW), .CW(CW)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (ctl_pos),
      .cnt     (cnt_r),
      .nbr_id  (c_id[(g + 1) % CAPACITY]),
      .nbr_pri (c_pri[(g + 1) % CAPACITY]),
      .id_r    (c_id[g]),
      .pri_r   (c_pri[g])
    );
  end

  // comparator at the head of the row; cell zero holds entry t_r
  logic in_range, above_last, better, take_min, take_match;
  assign in_range   = CW'(t_r) < cnt_r;
  assign above_last = !have_last_r || c_pri[0] > last_pri_r ||
                      (c_pri[0] == last_pri_r && t_r > last_idx_r);
  assign better     = !have_best_r || c_pri[0] < best_pri_r;
  assign take_min   = in_range && above_last && better;
  assign take_match = in_range && !have_best_r && c_id[0] == req_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r      <= in_ch.kind;
            req_id_r    <= in_ch.item_id;
            req_pri_r   <= in_ch.item_priority;
            rank_r      <= in_ch.rank;
            have_best_r <= 1'b0;
            have_last_r <= 1'b0;
            pass_r      <= 8'd1;
            t_r         <= '0;
            res_st_r    <= uaq_pkg::ST_OK;
            res_id_r    <= '0;
            res_pri_r   <= '0;
            state_r     <= S_RESULT;
            case (in_ch.kind)
              uaq_pkg::KIND_INSERT: begin
                if (cnt_r < CAP_C) cnt_r <= cnt_r + 1'b1;
                else res_st_r <= uaq_pkg::ST_FULL;
              end
              uaq_pkg::KIND_REMOVE: begin
                if (cnt_r == '0) res_st_r <= uaq_pkg::ST_EMPTY;
                else state_r <= S_SCAN;
              end
              uaq_pkg::KIND_UPDATE: begin
                if (cnt_r == '0) res_st_r <= uaq_pkg::ST_NOTFOUND;
                else state_r <= S_SCAN;
              end
              default: begin
                if (cnt_r == '0) res_st_r <= uaq_pkg::ST_EMPTY;
                else if (in_ch.rank == 8'd0 || RW'(in_ch.rank) > RW'(cnt_r))
                  res_st_r <= uaq_pkg::ST_RANK;
                else state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          // candidate bookkeeping for this step
          if (kind_r == uaq_pkg::KIND_UPDATE) begin
            if (take_match) begin
              have_best_r <= 1'b1;
              best_idx_r  <= t_r;
            end
          end else if (take_min) begin
            have_best_r <= 1'b1;
            best_idx_r  <= t_r;
            best_id_r   <= c_id[0];
            best_pri_r  <= c_pri[0];
          end
          if (t_r == LAST_T) begin
            t_r <= '0;
            case (kind_r)
              uaq_pkg::KIND_REMOVE: begin
                res_id_r  <= take_min ? c_id[0]  : best_id_r;
                res_pri_r <= take_min ? c_pri[0] : best_pri_r;
                state_r   <= S_APPLY;
              end
              uaq_pkg::KIND_UPDATE: begin
                if (have_best_r || take_match) begin
                  res_id_r  <= req_id_r;
                  res_pri_r <= req_pri_r;
                  state_r   <= S_APPLY;
                end else begin
                  res_st_r <= uaq_pkg::ST_NOTFOUND;
                  state_r  <= S_RESULT;
                end
              end
              default: begin
                if (pass_r == rank_r) begin
                  res_id_r  <= take_min ? c_id[0]  : best_id_r;
                  res_pri_r <= take_min ? c_pri[0] : best_pri_r;
                  state_r   <= S_RESULT;
                end else begin
                  pass_r      <= pass_r + 8'd1;
                  have_last_r <= 1'b1;
                  have_best_r <= 1'b0;
                  last_idx_r  <= take_min ? t_r      : best_idx_r;
                  last_pri_r  <= take_min ? c_pri[0] : best_pri_r;
                end
              end
            endcase
          end else begin
            t_r <= t_r + 1'b1;
          end
        end
        S_APPLY: begin
          if (kind_r == uaq_pkg::KIND_REMOVE) cnt_r <= cnt_r - 1'b1;
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            out_st_r    <= res_st_r;
            out_id_r    <= res_id_r;
            out_pri_r   <= res_pri_r;
            out_occ_r   <= 8'(cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.found_id       = out_id_r;
  assign out_ch.found_priority = out_pri_r;
  assign out_ch.occupancy      = out_occ_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP_C)
    else $error("fill count above capacity");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request accepted while previous one still in work");
  a_scan_idle_t: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_SCAN |-> t_r == '0)
    else $error("scan step counter not parked outside a scan");
  a_cnt_only_on_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_RESULT) |=> $stable(cnt_r))
    else $error("fill count moved during scan or result hand-off");

endmodule

// File: tb/uaq_scoreboard.sv
// Checker for the unsorted array priority queue: watches both channels,
// keeps its own copy of the store, predicts every result and compares it.
// Depends on uaq_pkg and the channel interfaces in uaq_if.
module uaq_scoreboard #(
  parameter int CAPACITY = 128
) (
  input  logic clk,
  input  logic rst_n,
  uaq_in_if    in_ch,
  uaq_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import uaq_pkg::*;

  typedef struct {
    logic [2:0]             status;
    logic [IdW-1:0]         found_id;
    logic signed [PriW-1:0] found_priority;
    logic [7:0]             occupancy;
  } answer_t;

  logic [IdW-1:0]         queue_ids[$];
  logic signed [PriW-1:0] queue_pris[$];
  answer_t                answers[$];

  assign pending = answers.size();

  initial fail_count = 0;

  function automatic answer_t serve(logic [1:0] kind, logic [IdW-1:0] id,
                                    logic signed [PriW-1:0] pri, logic [7:0] rank);
    answer_t a;
    int best;
    int pos;
    a.status = ST_OK;
    a.found_id = '0;
    a.found_priority = '0;
    case (kind)
      KIND_INSERT: begin
        if (queue_ids.size() < CAPACITY) begin
          queue_ids.push_back(id);
          queue_pris.push_back(pri);
        end else begin
          a.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (queue_ids.size() == 0) begin
          a.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < queue_pris.size(); i++)
            if (queue_pris[i] < queue_pris[best]) best = i;
          a.found_id = queue_ids[best];
          a.found_priority = queue_pris[best];
          queue_ids.delete(best);
          queue_pris.delete(best);
        end
      end
      KIND_UPDATE: begin
        a.status = ST_NOTFOUND;
        for (int i = 0; i < queue_ids.size(); i++) begin
          if (queue_ids[i] == id) begin
            queue_pris[i] = pri;
            a.found_id = id;
            a.found_priority = pri;
            a.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        if (queue_ids.size() == 0) begin
          a.status = ST_EMPTY;
        end else if (rank == 0 || rank > queue_ids.size()) begin
          a.status = ST_RANK;
        end else begin
          // removal order: lower priority first, earlier position on ties
          for (int i = 0; i < queue_ids.size(); i++) begin
            pos = 1;
            for (int j = 0; j < queue_ids.size(); j++)
              if (queue_pris[j] < queue_pris[i] ||
                  (queue_pris[j] == queue_pris[i] && j < i)) pos++;
            if (pos == rank) begin
              a.found_id = queue_ids[i];
              a.found_priority = queue_pris[i];
              break;
            end
          end
        end
      end
    endcase
    a.occupancy = 8'(queue_ids.size());
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        answers.push_back(serve(in_ch.kind, in_ch.item_id, in_ch.item_priority, in_ch.rank));
      if (out_ch.valid && out_ch.ready) begin
        if (answers.size() == 0) begin
          $error("result with nothing expected: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.found_id !== want.found_id) begin
            $error("found_id: expected %0d, got %0d", want.found_id, out_ch.found_id);
            fail_count++;
          end
          if (out_ch.found_priority !== want.found_priority) begin
            $error("found_priority: expected %0d, got %0d",
                   want.found_priority, out_ch.found_priority);
            fail_count++;
          end
          if (out_ch.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_ch.occupancy);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/unsorted_array_priority_queue_test.sv
// Top of the priority queue testbench: clock, reset, request stimulus and
// result back-pressure; the verdict comes from uaq_scoreboard.
// Depends on uaq_pkg, uaq_if, the block and the scoreboard.
module unsorted_array_priority_queue_test;
  import uaq_pkg::*;

  localparam int CAPACITY  = 128;
  localparam int RAND_ITEMS = 1250;
  // kth search costs a full row pass per rank; limit covers every item at
  // the deepest rank with the longest stalls, more than twice over
  localparam longint CYCLE_LIMIT = 100000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  longint cycles;
  bit   calm;            // when set both sides run without gaps
  int   sent[4];         // items sent per kind
  int   occ_guess;       // rough fill level, steers the stimulus only

  uaq_in_if  in_ch();
  uaq_out_if out_ch();

  unsorted_array_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  uaq_scoreboard #(.CAPACITY(CAPACITY)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall before each item, none while calm
  initial begin
    int stall;
    out_ch.ready = 0;
    stall = 0;
    @(posedge clk);
    forever begin
      if (!rst_n) begin
        out_ch.ready <= 0;
      end else begin
        if (out_ch.valid && out_ch.ready)
          stall = calm ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_ch.ready <= 0;
          stall--;
        end else begin
          out_ch.ready <= 1;
        end
      end
      @(posedge clk);
    end
  end

  // One request item; valid is held across back-to-back items.
  task automatic send(logic [1:0] kind, logic [IdW-1:0] id,
                      logic signed [PriW-1:0] pri, logic [7:0] rank);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1;
    in_ch.kind          <= kind;
    in_ch.item_id       <= id;
    in_ch.item_priority <= pri;
    in_ch.rank          <= rank;
    do @(posedge clk); while (!in_ch.ready);
    sent[kind]++;
    case (kind)
      KIND_INSERT: if (occ_guess < CAPACITY) occ_guess++;
      KIND_REMOVE: if (occ_guess > 0) occ_guess--;
      default: ;
    endcase
  endtask

  function automatic logic [IdW-1:0] pick_id();
    // small pool so updates usually hit an entry
    return ($urandom_range(0, 9) < 7) ? IdW'($urandom_range(0, 15)) : IdW'($urandom);
  endfunction

  function automatic logic signed [PriW-1:0] pick_pri();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PriW'($signed($urandom_range(0, 4)) - 2);  // ties
    if (r == 5) return 32'sh8000_0000;
    if (r == 6) return 32'sh7fff_ffff;
    return PriW'($urandom);
  endfunction

  function automatic logic [7:0] pick_rank();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'(occ_guess + 1);                      // just past the end
    if (r < 6) return 8'd0;
    if (r < 8) return 8'($urandom);                          // any bits, rarely deep
    if (r < 11) return 8'(occ_guess);
    return 8'($urandom_range(1, 4));
  endfunction

  initial begin
    int ins_pct;
    int r;
    rst_n               = 0;
    calm                = 0;
    occ_guess           = 0;
    in_ch.valid         = 0;
    in_ch.kind          = KIND_INSERT;
    in_ch.item_id       = '0;
    in_ch.item_priority = '0;
    in_ch.rank          = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty store corners, field extremes, ties, rank bounds
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_UPDATE, 16'd5, 32'sd9, 8'd0);
    send(KIND_KTH,    16'd0, 0, 8'd1);
    send(KIND_INSERT, 16'd0, 32'sh7fff_ffff, 8'd0);
    send(KIND_INSERT, 16'hffff, 32'sh8000_0000, 8'hff);
    send(KIND_INSERT, 16'd7, 32'sd3, 8'd0);
    send(KIND_INSERT, 16'd8, 32'sd3, 8'd0);          // tie with entry 7
    send(KIND_KTH,    16'd0, 0, 8'd0);
    send(KIND_KTH,    16'd0, 0, 8'd1);
    send(KIND_KTH,    16'd0, 0, 8'd3);
    send(KIND_KTH,    16'd0, 0, 8'd4);
    send(KIND_KTH,    16'd0, 0, 8'd5);
    send(KIND_KTH,    16'd0, 0, 8'hff);
    send(KIND_UPDATE, 16'd1234, 32'sd1, 8'd0);       // no such id
    send(KIND_UPDATE, 16'hffff, 32'sd3, 8'd0);       // now three-way tie
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_INSERT, 16'd7, -32'sd1, 8'd0);         // reuses id 7, whose first entry was removed above
    send(KIND_UPDATE, 16'd7, 32'sh8000_0000, 8'd0);  // the only entry with id 7
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_REMOVE, 16'd0, 0, 8'd0);
    send(KIND_REMOVE, 16'd0, 0, 8'd0);

    // random phases: fill-heavy, balanced and drain-heavy mixes
    ins_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 45;
          default: ins_pct = 15;
        endcase
        calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < ins_pct)
        send(KIND_INSERT, pick_id(), pick_pri(), 8'($urandom));
      else if (r < ins_pct + (100 - ins_pct) / 2)
        send(KIND_REMOVE, IdW'($urandom), PriW'($urandom), 8'($urandom));
      else if ($urandom_range(0, 1) == 0)
        send(KIND_UPDATE, pick_id(), pick_pri(), 8'($urandom));
      else
        send(KIND_KTH, IdW'($urandom), PriW'($urandom), pick_rank());
    end
    in_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d inserts, %0d remove-min, %0d updates, %0d k-th searches",
             sent[KIND_INSERT], sent[KIND_REMOVE], sent[KIND_UPDATE], sent[KIND_KTH]);
    $display("with random gaps and stalls on both channels, %0d mismatches", fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/uaq_pkg.sv
rtl/uaq_if.sv
rtl/uaq_cell.sv
rtl/unsorted_array_priority_queue.sv
tb/uaq_scoreboard.sv
tb/unsorted_array_priority_queue_test.sv
